### sv/falc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package falc_pkg;

  localparam int CmdWidth   = 1;
  localparam int AddrWidth  = 14;
  localparam int DataWidth  = 32;
  localparam int WayOutW    = 4;
  localparam int BlockOutW  = 9;
  localparam int CountWidth = 32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WB,
    ST_FILL,
    ST_ACCESS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CmdWidth-1:0]  command;
    logic [AddrWidth-1:0] address;
    logic [DataWidth-1:0] store_data;
  } req_t;

  typedef struct packed {
    logic [DataWidth-1:0]  load_data;
    logic                  hit;
    logic [WayOutW-1:0]    way;
    logic                  filled_empty;
    logic                  wrote_back;
    logic [BlockOutW-1:0]  victim_block;
    logic [CountWidth-1:0] read_query_count;
    logic [CountWidth-1:0] read_miss_count;
    logic [CountWidth-1:0] write_query_count;
    logic [CountWidth-1:0] write_miss_count;
  } rsp_t;

endpackage
`default_nettype wire

### sv/falc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface falc_req_if
  import falc_pkg::*;
();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface falc_rsp_if
  import falc_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/fully_assoc_lru_writeback_cache_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Fully associative write-back, write-allocate cache with LRU replacement in
// front of an internal backing memory. After reset a clearing pass zeroes the
// backing memory, one word a cycle, before the first word is taken. One access
// is in flight at a time and its tags are searched in the cycle the word is
// taken. A hit passes through ST_ACCESS and ST_DONE into the output register,
// and the next word is taken once the state is back in ST_IDLE. A miss first
// fetches the block through the single-port memories in ST_FILL, and a dirty
// victim is written back before that in ST_WB. A finished access waits only
// while the previous result is still held unaccepted.
module fully_assoc_lru_writeback_cache_top
  import falc_pkg::*;
#(
  parameter int WAY_COUNT    = 16,
  parameter int BLOCK_BYTES  = 32,
  parameter int MEMORY_BYTES = 16384
) (
  input  wire logic   clk,
  input  wire logic   rst,
  falc_req_if.sink    req,
  falc_rsp_if.source  rsp
);

  localparam int WordsPerBlock = BLOCK_BYTES / 4;
  localparam int MemWords      = MEMORY_BYTES / 4;
  localparam int WayW          = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int OffBits       = $clog2(WordsPerBlock);
  localparam int OffW          = (OffBits > 0) ? OffBits : 1;
  localparam int MemW          = $clog2(MemWords);
  localparam int BlkW          = MemW - OffBits;
  localparam int TagW          = (BlkW > 0) ? BlkW : 1;
  localparam int LineW         = WayW + OffW;
  localparam int InWordW       = AddrWidth - 2;

  state_t state, state_next;

  // memories
  logic [DataWidth-1:0] back_mem [MemWords];
  logic [DataWidth-1:0] line_mem [2**LineW];

  // per-way state
  logic [TagW-1:0]      tag_reg [WAY_COUNT];
  logic [WayW-1:0]      order   [WAY_COUNT];
  logic [WAY_COUNT-1:0] valid_bits, dirty_bits;

  logic                 bm_we;
  logic [MemW-1:0]      bm_addr;
  logic [DataWidth-1:0] bm_wdata, bm_rdata;
  logic                 lm_we;
  logic [LineW-1:0]     lm_addr;
  logic [DataWidth-1:0] lm_wdata, lm_rdata;

  always_ff @(posedge clk) begin
    if (bm_we) begin
      back_mem[bm_addr] <= bm_wdata;
    end
    bm_rdata <= back_mem[bm_addr];
  end

  always_ff @(posedge clk) begin
    if (lm_we) begin
      line_mem[lm_addr] <= lm_wdata;
    end
    lm_rdata <= line_mem[lm_addr];
  end

  // incoming word
  logic [InWordW-1:0] in_word;
  logic [MemW-1:0]    in_widx;
  logic [TagW-1:0]    in_blk;
  logic [OffW-1:0]    in_off;

  assign in_word = req.data.address[AddrWidth-1:2];
  assign in_widx = MemW'(in_word);
  assign in_blk  = TagW'(in_widx >> OffBits);
  assign in_off  = OffW'(in_widx & MemW'(WordsPerBlock - 1));

  // captured access
  logic                  is_store;
  logic [TagW-1:0]       blk, victim;
  logic [OffW-1:0]       off;
  logic [DataWidth-1:0]  sdata;
  logic [WayW-1:0]       way;
  logic                  hit, filled_empty, wrote_back;
  logic [MemW-1:0]       clr_idx;
  logic [OffW:0]         wcnt;
  logic [CountWidth-1:0] rq, rm, wq, wm;
  rsp_t                  out_reg;
  logic                  out_valid, out_load, accept, wcnt_end;
  logic [MemW-1:0]       vict_base, blk_base;

  logic                  in_hit, any_free, evict_dirty;
  logic [WayW-1:0]       hit_way, first_free, lru_way;
  logic                  seen;
  logic [WAY_COUNT-1:1]  shift_en;

  always_comb begin
    in_hit     = 1'b0;
    hit_way    = '0;
    any_free   = 1'b0;
    first_free = '0;
    for (int i = WAY_COUNT - 1; i >= 0; i--) begin
      if (valid_bits[i] && tag_reg[i] == in_blk) begin
        in_hit  = 1'b1;
        hit_way = WayW'(i);
      end
      if (!valid_bits[i]) begin
        any_free   = 1'b1;
        first_free = WayW'(i);
      end
    end
  end

  assign lru_way     = order[WAY_COUNT-1];
  assign evict_dirty = !in_hit && !any_free && dirty_bits[lru_way];

  // shift every list entry below the accessed way's position up by one
  always_comb begin
    seen = 1'b0;
    for (int i = WAY_COUNT - 1; i >= 1; i--) begin
      seen        = seen | (order[i] == way);
      shift_en[i] = seen;
    end
  end

  assign vict_base = MemW'(victim) << OffBits;
  assign blk_base  = MemW'(blk) << OffBits;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign out_load  = (state == ST_DONE) && (!out_valid || rsp.ready);
  assign wcnt_end  = (wcnt == (OffW+1)'(WordsPerBlock));
  assign rsp.valid = out_valid;
  assign rsp.data  = out_reg;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_idx == MemW'(MemWords - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_hit) state_next = ST_ACCESS;
          else if (evict_dirty) state_next = ST_WB;
          else state_next = ST_FILL;
        end
      end
      ST_WB:     if (wcnt_end) state_next = ST_FILL;
      ST_FILL:   if (wcnt_end) state_next = ST_ACCESS;
      ST_ACCESS: state_next = ST_DONE;
      ST_DONE:   if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    bm_we = 1'b0; bm_addr = blk_base + MemW'(wcnt); bm_wdata = lm_rdata;
    lm_we = 1'b0; lm_addr = {way, off}; lm_wdata = bm_rdata;
    case (state)
      ST_CLEAR: begin
        bm_we = 1'b1; bm_addr = clr_idx; bm_wdata = '0;
      end
      ST_WB: begin
        // read line word wcnt, store the previously read word at wcnt-1
        lm_addr = {way, OffW'(wcnt)};
        bm_we   = (wcnt != '0);
        bm_addr = vict_base + MemW'(wcnt - 1'b1);
      end
      ST_FILL: begin
        bm_addr = blk_base + MemW'(wcnt);
        lm_we   = (wcnt != '0);
        lm_addr = {way, OffW'(wcnt - 1'b1)};
      end
      ST_ACCESS: begin
        lm_we    = is_store;
        lm_wdata = sdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      valid_bits <= '0;
      dirty_bits <= '0;
      out_valid  <= 1'b0;
      rq <= '0; rm <= '0; wq <= '0; wm <= '0;
      wcnt       <= '0;
      for (int i = 0; i < WAY_COUNT; i++) order[i] <= WayW'(WAY_COUNT - 1 - i);
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: clr_idx <= clr_idx + 1'b1;
        ST_IDLE: begin
          if (accept) begin
            is_store     <= (req.data.command == CMD_STORE);
            blk          <= in_blk;
            off          <= in_off;
            sdata        <= req.data.store_data;
            wcnt         <= '0;
            hit          <= in_hit;
            filled_empty <= !in_hit && any_free;
            wrote_back   <= evict_dirty;
            victim       <= evict_dirty ? tag_reg[lru_way] : '0;
            if (in_hit) way <= hit_way;
            else if (any_free) way <= first_free;
            else way <= lru_way;
          end
        end
        ST_WB: begin
          if (wcnt_end) wcnt <= '0;
          else wcnt <= wcnt + 1'b1;
        end
        ST_FILL: begin
          if (wcnt_end) begin
            wcnt            <= '0;
            tag_reg[way]    <= blk;
            valid_bits[way] <= 1'b1;
            dirty_bits[way] <= 1'b0;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        ST_ACCESS: begin
          if (is_store) begin
            dirty_bits[way] <= 1'b1;
            wq <= wq + 1'b1;
            if (!hit) wm <= wm + 1'b1;
          end else begin
            rq <= rq + 1'b1;
            if (!hit) rm <= rm + 1'b1;
          end
          order[0] <= way;
          for (int i = 1; i < WAY_COUNT; i++) begin
            if (shift_en[i]) order[i] <= order[i-1];
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_reg.load_data         <= is_store ? '0 : lm_rdata;
            out_reg.hit               <= hit;
            out_reg.way               <= WayOutW'(way);
            out_reg.filled_empty      <= filled_empty;
            out_reg.wrote_back        <= wrote_back;
            out_reg.victim_block      <= BlockOutW'(victim);
            out_reg.read_query_count  <= rq;
            out_reg.read_miss_count   <= rm;
            out_reg.write_query_count <= wq;
            out_reg.write_miss_count  <= wm;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !req.ready) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && rsp.ready) |=> out_valid) else $error("result lost");
  a_wb_dirty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB) |-> (wrote_back && !hit)) else $error("writeback on hit");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
    else $error("result word changed while waiting");
`endif

endmodule
`default_nettype wire
